@@ sv/crlf_lr_pkg.sv @@
// Package for the CR LF line receiver: character codes, operation codes,
// read phase type and the structs passed between control, store and top.
// No dependencies.
`timescale 1ns / 1ps

package crlf_lr_pkg;

	localparam int LINE_LEN_DEF = 256;

	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	localparam logic OP_RX   = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_READ = 2'd2
	} phase_t;

	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

	typedef struct packed {
		logic has_char;
		logic newline;
		logic line_ready;
	} res_t;

endpackage

@@ sv/crlf_line_receiver_core.sv @@
// Top level of the CR LF line receiver: request channel, control, line store
// and the result register. Depends on crlf_lr_pkg, crlf_lr_ctrl, crlf_lr_store.
//
//  channel   signals                                  role
//  request   req_valid, req_stall, operation, rx_byte  in: byte received or read
//  response  rsp_valid, rsp_stall, has_char, char_out, line_ready
//                                                      out: one result per item
//
// One item per cycle while req_stall is low; each result appears in the cycle after its item is
// taken, from the result register and the registered read port of the line store.
// Reset clears count, length, flags, phase and index; the store is not cleared.
// req_stall is high only while a result is held and rsp_stall is high.
`timescale 1ns / 1ps

module crlf_line_receiver_core #(
	parameter int LINE_LEN = crlf_lr_pkg::LINE_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       operation,
	input  logic [7:0] rx_byte,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic       has_char,
	output logic [7:0] char_out,
	output logic       line_ready
);
	import crlf_lr_pkg::*;

	localparam int AW = $clog2(LINE_LEN);

	logic          accept;
	mem_ctl_t      mem_ctl;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;
	res_t          res_d, res_s1;
	logic          valid_s1;

	assign req_stall = valid_s1 && rsp_stall;
	assign accept    = req_valid && !req_stall;

	crlf_lr_ctrl #(.LINE_LEN(LINE_LEN)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.rx_byte   (rx_byte),
		.mem_ctl   (mem_ctl),
		.waddr     (waddr),
		.wdata     (wdata),
		.raddr     (raddr),
		.res       (res_d)
	);

	crlf_lr_store #(.LINE_LEN(LINE_LEN)) u_store (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

	assign rsp_valid  = valid_s1;
	assign has_char   = res_s1.has_char;
	assign line_ready = res_s1.line_ready;
	assign char_out   = res_s1.newline  ? CHAR_LF :
	                    res_s1.has_char ? rdata   : CHAR_NUL;

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("request stalled without a held result");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted item produced no result");

	a_line_end_newline: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && has_char && !line_ready) |-> (char_out == CHAR_LF))
		else $error("line released without newline");

endmodule

@@ sv/crlf_lr_store.sv @@
// Line store: one write port, one read port with registered read data.
// Depends on crlf_lr_pkg.
`timescale 1ns / 1ps

module crlf_lr_store #(
	parameter int LINE_LEN = crlf_lr_pkg::LINE_LEN_DEF,
	localparam int AW = $clog2(LINE_LEN)
) (
	input  logic                  clk,
	input  crlf_lr_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]         waddr,
	input  logic [7:0]            wdata,
	input  logic [AW-1:0]         raddr,
	output logic [7:0]            rdata
);
	import crlf_lr_pkg::*;

	logic [7:0] mem [LINE_LEN];
	logic [7:0] rd_s1;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rd_s1 <= mem[raddr];
		end
	end

	assign rdata = rd_s1;

endmodule

@@ sv/crlf_lr_ctrl.sv @@
// Line assembly and read-out control: CR/LF tracking, byte count, latched
// length, read index and read phase. Depends on crlf_lr_pkg.
`timescale 1ns / 1ps

module crlf_lr_ctrl #(
	parameter int LINE_LEN = crlf_lr_pkg::LINE_LEN_DEF,
	localparam int AW = $clog2(LINE_LEN)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  operation,
	input  logic [7:0]            rx_byte,
	output crlf_lr_pkg::mem_ctl_t mem_ctl,
	output logic [AW-1:0]         waddr,
	output logic [7:0]            wdata,
	output logic [AW-1:0]         raddr,
	output crlf_lr_pkg::res_t     res
);
	import crlf_lr_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(LINE_LEN - 1);

	phase_t        phase_q, phase_d;
	logic          cr_q, cr_d;
	logic [AW-1:0] count_q, count_d;
	logic [AW-1:0] len_q, len_d;
	logic [AW-1:0] idx_q, idx_d;

	logic is_rx, is_rd, done, last;
	logic [AW-1:0] rd_addr;

	assign is_rx   = accept && (operation == OP_RX);
	assign is_rd   = accept && (operation == OP_READ);
	assign done    = (phase_q != PH_IDLE);
	assign rd_addr = (phase_q == PH_WAIT) ? '0 : idx_q;
	assign last    = (rd_addr == len_q);

	// next state
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (is_rx && cr_q && (rx_byte == CHAR_LF)) begin
					phase_d = PH_WAIT;
				end
			end
			PH_WAIT, PH_READ: begin
				if (is_rd) begin
					phase_d = last ? PH_IDLE : PH_READ;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// outputs and datapath
	always_comb begin
		cr_d        = cr_q;
		count_d     = count_q;
		len_d       = len_q;
		idx_d       = idx_q;
		mem_ctl.we  = 1'b0;
		mem_ctl.re  = 1'b0;
		waddr       = count_q;
		wdata       = rx_byte;
		raddr       = rd_addr;
		if (is_rx && !done) begin
			if (cr_q) begin
				if (rx_byte == CHAR_LF) begin
					len_d = count_q;
				end else begin
					count_d = '0;
					cr_d    = 1'b0;
				end
			end else if (rx_byte == CHAR_CR) begin
				cr_d = 1'b1;
			end else begin
				mem_ctl.we = 1'b1;
				count_d    = (count_q == LAST) ? '0 : AW'(count_q + 1'b1);
			end
		end
		if (is_rd && done) begin
			mem_ctl.re = 1'b1;
			idx_d      = AW'(rd_addr + 1'b1);
			if (last) begin
				count_d = '0;
				cr_d    = 1'b0;
			end
		end
		res.has_char   = is_rd && done;
		res.newline    = is_rd && done && last;
		res.line_ready = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cr_q    <= 1'b0;
			count_q <= '0;
			len_q   <= '0;
			idx_q   <= '0;
		end else begin
			phase_q <= phase_d;
			cr_q    <= cr_d;
			count_q <= count_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
		end
	end

endmodule

@@ bench/tb_crlf_line_receiver_core.sv @@
// Self-checking bench for crlf_line_receiver_core: plans CR LF lines, broken lines and noise,
// predicts every result from its own line model and checks each result in order.
// Depends on crlf_lr_pkg and crlf_line_receiver_core.
`timescale 1ns / 1ps

module tb_crlf_line_receiver_core;
	import crlf_lr_pkg::*;

	localparam int CHECK_COPY = 0;
	localparam int PLAN_COPY  = 1;
	localparam int MAX_SHOWN  = 40;

	typedef struct packed {
		logic       op;
		logic [7:0] b;
	} line_item_t;

	typedef struct packed {
		logic       has_char;
		logic [7:0] ch;
		logic       ready;
	} line_res_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic       operation = OP_RX;
	logic [7:0] rx_byte = 8'h00;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	logic       has_char;
	logic [7:0] char_out;
	logic       line_ready;

	// two copies of the line model: one checks results, one steers the stimulus
	logic [7:0] lm_store [0:511];
	logic [7:0] lm_count [0:1];
	logic       lm_cr    [0:1];
	logic       lm_done  [0:1];
	phase_t     lm_phase [0:1];
	logic [7:0] lm_len   [0:1];
	logic [8:0] lm_idx   [0:1];

	line_item_t stim_q[$];
	line_res_t  pending_res[$];
	line_item_t nxt_item;
	line_res_t  want;

	int  n_errors = 0;
	int  n_taken = 0;
	int  n_results = 0;
	int  n_planned = 0;
	int  n_lines = 0;
	int  n_wraps = 0;
	int  send_gap = 0;
	int  hold_left = 0;
	bit  idle_off = 1'b0;
	bit  long_hold_go = 1'b0;
	bit  long_hold_done = 1'b0;

	crlf_line_receiver_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.operation(operation),
		.rx_byte(rx_byte),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.has_char(has_char),
		.char_out(char_out),
		.line_ready(line_ready)
	);

	always #5 clk = ~clk;

	task automatic clear_copy(input int m);
		lm_count[m] = '0;
		lm_cr[m] = 1'b0;
		lm_done[m] = 1'b0;
		lm_phase[m] = PH_IDLE;
		lm_len[m] = '0;
		lm_idx[m] = '0;
	endtask

	function automatic line_res_t advance_line(input int m, input line_item_t it);
		line_res_t r;
		int base;
		r = '0;
		base = m * 256;
		if (it.op == OP_RX) begin
			if (!lm_done[m]) begin
				if (lm_cr[m]) begin
					if (it.b != CHAR_LF) begin
						lm_count[m] = '0;
						lm_cr[m] = 1'b0;
					end else begin
						lm_done[m] = 1'b1;
						lm_phase[m] = PH_WAIT;
						lm_len[m] = lm_count[m];
					end
				end else if (it.b == CHAR_CR) begin
					lm_cr[m] = 1'b1;
				end else begin
					lm_store[base + lm_count[m]] = it.b;
					lm_count[m] = lm_count[m] + 8'd1;
				end
			end
		end else if (lm_phase[m] != PH_IDLE) begin
			if (lm_phase[m] == PH_WAIT) begin
				lm_phase[m] = PH_READ;
				lm_idx[m] = '0;
			end
			r.has_char = 1'b1;
			r.ch = lm_store[base + lm_idx[m][7:0]];
			lm_idx[m] = lm_idx[m] + 9'd1;
			if (lm_idx[m] > {1'b0, lm_len[m]}) begin
				lm_phase[m] = PH_IDLE;
				lm_count[m] = '0;
				lm_cr[m] = 1'b0;
				lm_done[m] = 1'b0;
				r.ch = CHAR_LF;
			end
		end
		r.ready = lm_done[m];
		return r;
	endfunction

	task automatic plan_item(input logic op, input logic [7:0] b, input bit counted);
		bit was_done;
		was_done = lm_done[PLAN_COPY];
		void'(advance_line(PLAN_COPY, {op, b}));
		if (!was_done && lm_done[PLAN_COPY])
			n_lines++;
		if (counted)
			n_planned++;
		stim_q.push_back({op, b});
	endtask

	task automatic release_line;
		while (lm_done[PLAN_COPY])
			plan_item(OP_READ, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic plan_line(input int len);
		logic [7:0] b;
		release_line();
		if (lm_cr[PLAN_COPY]) begin
			b = 8'($urandom_range(0, 255));
			if (b == CHAR_LF)
				b = 8'h5A;
			plan_item(OP_RX, b, 1'b1);
		end
		if (len >= 256)
			n_wraps++;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			if (b == CHAR_CR)
				b = 8'hF2;
			if ($urandom_range(0, 15) == 0)
				plan_item(OP_READ, 8'($urandom_range(0, 255)), 1'b1);
			plan_item(OP_RX, b, 1'b1);
		end
		plan_item(OP_RX, CHAR_CR, 1'b1);
		plan_item(OP_RX, CHAR_LF, 1'b1);
		while (lm_done[PLAN_COPY]) begin
			if ($urandom_range(0, 7) == 0)
				plan_item(OP_RX, 8'($urandom_range(0, 255)), 1'b0);
			plan_item(OP_READ, 8'($urandom_range(0, 255)), 1'b1);
		end
		if ($urandom_range(0, 3) == 0)
			plan_item(OP_READ, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic plan_random(input int n);
		int stop;
		int pick;
		int k;
		logic [7:0] b;
		stop = n_planned + n;
		while (n_planned < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				plan_line($urandom_range(0, 12));
			end else if (pick < 88) begin
				release_line();
				k = $urandom_range(0, 5);
				for (int i = 0; i < k; i++) begin
					b = 8'($urandom_range(0, 255));
					if (b == CHAR_CR)
						b = 8'h2D;
					plan_item(OP_RX, b, 1'b1);
				end
				plan_item(OP_RX, CHAR_CR, 1'b1);
				b = 8'($urandom_range(0, 255));
				if (b == CHAR_LF)
					b = CHAR_CR;
				plan_item(OP_RX, b, 1'b1);
			end else begin
				k = $urandom_range(1, 8);
				for (int i = 0; i < k; i++)
					plan_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		n_errors++;
		if (n_errors <= MAX_SHOWN)
			$display("mismatch at result %0d: %s got %0h want %0h", n_results, what, got,
				exp_val);
	endtask

	task automatic wait_drained;
		@(negedge clk);
		while (stim_q.size() != 0 || req_valid || pending_res.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			operation <= OP_RX;
			rx_byte <= 8'h00;
			send_gap <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				pending_res.push_back(advance_line(CHECK_COPY, {operation, rx_byte}));
				n_taken++;
			end
			if (!req_valid || !req_stall) begin
				if (send_gap > 0) begin
					req_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (!idle_off && $urandom_range(0, 9) == 0) begin
					req_valid <= 1'b0;
					send_gap <= $urandom_range(0, 15);
				end else if (stim_q.size() != 0) begin
					nxt_item = stim_q.pop_front();
					req_valid <= 1'b1;
					operation <= nxt_item.op;
					rx_byte <= nxt_item.b;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_res.size() == 0) begin
					report_mismatch("result with nothing pending", char_out, 0);
				end else begin
					want = pending_res.pop_front();
					if (has_char !== want.has_char)
						report_mismatch("has_char", has_char, want.has_char);
					if (char_out !== want.ch)
						report_mismatch("char_out", char_out, want.ch);
					if (line_ready !== want.ready)
						report_mismatch("line_ready", line_ready, want.ready);
				end
				n_results++;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (long_hold_go && !long_hold_done) begin
				rsp_stall <= 1'b1;
				hold_left <= 299;
				long_hold_done <= 1'b1;
			end else if (!idle_off && $urandom_range(0, 9) == 0) begin
				rsp_stall <= 1'b1;
				hold_left <= $urandom_range(0, 15);
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		clear_copy(CHECK_COPY);
		clear_copy(PLAN_COPY);

		plan_item(OP_READ, 8'hA5, 1'b1);
		plan_item(OP_RX, CHAR_CR, 1'b1);
		plan_item(OP_RX, CHAR_LF, 1'b1);
		plan_item(OP_RX, 8'h41, 1'b0);
		plan_item(OP_READ, 8'h5A, 1'b1);
		plan_item(OP_RX, 8'h00, 1'b1);
		plan_item(OP_RX, 8'hFF, 1'b1);
		plan_item(OP_RX, CHAR_LF, 1'b1);
		plan_item(OP_RX, CHAR_CR, 1'b1);
		plan_item(OP_RX, CHAR_LF, 1'b1);
		repeat (4) plan_item(OP_READ, 8'hFF, 1'b1);
		plan_item(OP_RX, 8'h55, 1'b1);
		plan_item(OP_RX, CHAR_CR, 1'b1);
		plan_item(OP_RX, 8'h33, 1'b1);
		plan_item(OP_RX, 8'hAA, 1'b1);
		plan_item(OP_RX, CHAR_CR, 1'b1);
		plan_item(OP_RX, CHAR_LF, 1'b1);
		repeat (2) plan_item(OP_READ, 8'h00, 1'b1);
		plan_item(OP_RX, CHAR_CR, 1'b1);
		plan_item(OP_RX, CHAR_CR, 1'b1);
		plan_item(OP_READ, 8'h00, 1'b1);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait_drained();

		plan_random(200);
		long_hold_go = 1'b1;
		wait_drained();

		plan_line(256);
		plan_line(255);
		plan_line($urandom_range(257, 300));
		plan_random(200);
		wait_drained();

		idle_off = 1'b1;
		plan_random(300);
		wait_drained();
		repeat (20) @(posedge clk);

		$display("covered %0d items and %0d results: %0d complete lines, %0d past the store size,",
			n_taken, n_results, n_lines, n_wraps);
		$display("plus broken lines, noise, reads with no line and one long output hold-off");
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout with %0d results still pending", pending_res.size());
		$display("simulation failed");
		$finish;
	end

endmodule
